[sv/ohc_pkg.sv]
// Shared types, constants and helpers for the one-at-a-time hash color block.
`timescale 1ns / 1ps

package ohc_pkg;

   localparam int unsigned HashWidth  = 32;
   localparam int unsigned LevelWidth = 8;

   // per-byte mixing shifts
   localparam int unsigned MixShiftLeft  = 10;
   localparam int unsigned MixShiftRight = 6;

   // final mixing shifts
   localparam int unsigned FinShiftA = 3;
   localparam int unsigned FinShiftB = 11;
   localparam int unsigned FinShiftC = 15;

   localparam logic [LevelWidth-1:0] MinLevelReset = 8'd20;

   typedef logic [HashWidth-1:0]  hash_type;
   typedef logic [LevelWidth-1:0] level_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      hash_type  hash_value;
      level_type red_level;
      level_type green_level;
      level_type blue_level;
   } rsp_type;

   // one byte into the running hash: add, add <<10, xor >>6
   function automatic hash_type mix_byte(hash_type h, logic [7:0] b);
      hash_type t;
      t = h + {24'd0, b};
      t = t + (t << MixShiftLeft);
      t = t ^ (t >> MixShiftRight);
      return t;
   endfunction

   function automatic level_type raise_level(level_type lvl, level_type floor_lvl);
      return (lvl < floor_lvl) ? floor_lvl : lvl;
   endfunction

endpackage

[sv/ohc_mix.sv]
// Running hash register and the finalize stage register.
`timescale 1ns / 1ps

module ohc_mix import ohc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_payload,
   output logic     fin_valid,
   input  logic     fin_ready,
   output hash_type fin_hash
);

   hash_type running_ff, running_in;
   hash_type fin_hash_ff, fin_hash_in;
   logic     fin_valid_ff, fin_valid_in;
   hash_type mixed;
   logic     accept;

   assign req_ready = !fin_valid_ff || fin_ready;
   assign accept    = req_valid && req_ready;
   assign mixed     = req_payload.has_byte ? mix_byte(running_ff, req_payload.data_byte)
                                           : running_ff;

   always_comb begin
      running_in   = running_ff;
      fin_hash_in  = fin_hash_ff;
      fin_valid_in = fin_valid_ff && !fin_ready;
      if (accept) begin
         if (req_payload.last_byte) begin
            running_in   = '0;
            fin_hash_in  = mixed;
            fin_valid_in = 1'b1;
         end else begin
            running_in = mixed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= '0;
         fin_valid_ff <= 1'b0;
      end else begin
         running_ff   <= running_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_hash_ff <= fin_hash_in;
   end

   assign fin_valid = fin_valid_ff;
   assign fin_hash  = fin_hash_ff;

endmodule

[sv/ohc_final.sv]
// Final avalanche mixing, color channel floor and the result register.
`timescale 1ns / 1ps

module ohc_final import ohc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      fin_valid,
   output logic      fin_ready,
   input  hash_type  fin_hash,
   input  level_type min_level,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_payload
);

   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff, rsp_data_in;
   hash_type h1, h2, h3;

   assign fin_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      h1 = fin_hash + (fin_hash << FinShiftA);
      h2 = h1 ^ (h1 >> FinShiftB);
      h3 = h2 + (h2 << FinShiftC);
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fin_valid && fin_ready) begin
         rsp_data_in.hash_value  = h3;
         rsp_data_in.red_level   = raise_level(h3[7:0], min_level);
         rsp_data_in.green_level = raise_level(h3[15:8], min_level);
         rsp_data_in.blue_level  = raise_level(h3[23:16], min_level);
         rsp_valid_in            = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

[sv/oaat_hash_color.sv]
// Top level of the one-at-a-time name hash with color channel outputs.
//
// Usage:
//   req_*  : one request per name byte (data_byte, has_byte, last_byte).
//            has_byte low carries no byte; last_byte ends the name.
//   rsp_*  : one result per name, on the request marked last: the
//            finalized 32-bit hash and red/green/blue levels from hash
//            bytes 0..2, each raised to the floor in csr_wdata.
//   csr_*  : csr_we writes the channel floor (reset value 20).
// Timing: one request per cycle sustained while rsp_ready stays high. The
// byte mix runs in the accept cycle into the running hash register, or
// for the last request into the finalize register, which feeds the final
// mix into the result register that drives rsp_valid.
// Reset: running hash cleared, no result pending, floor back to 20.
// Stall: while rsp_ready is low the result holds; one more finished
// name waits in the finalize register, after which req_ready drops.
`timescale 1ns / 1ps

module oaat_hash_color import ohc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_payload,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_payload,
   input  logic      csr_we,
   input  level_type csr_wdata
);

   level_type min_level_ff, min_level_in;
   logic      fin_valid, fin_ready;
   hash_type  fin_hash;

   assign min_level_in = csr_we ? csr_wdata : min_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_level_ff <= MinLevelReset;
      end else begin
         min_level_ff <= min_level_in;
      end
   end

   ohc_mix u_mix (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .fin_valid   (fin_valid),
      .fin_ready   (fin_ready),
      .fin_hash    (fin_hash)
   );

   ohc_final u_final (
      .clock       (clock),
      .reset       (reset),
      .fin_valid   (fin_valid),
      .fin_ready   (fin_ready),
      .fin_hash    (fin_hash),
      .min_level   (min_level_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !fin_valid)
      else $error("pipeline not empty after reset");

   a_last_loads_fin: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.last_byte |=> fin_valid)
      else $error("last request did not reach finalize stage");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(fin_valid))
      else $error("result appeared without a finalize entry");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      fin_valid && !fin_ready |=> fin_valid && $stable(fin_hash))
      else $error("stalled finalize entry changed");

endmodule
